[sv/histogram_equalizer_top_defines.svh]
// assertion macros shared by the histogram equalizer checker
`ifndef HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/heq_pkg.sv]
// types and constants of the histogram equalizer
`timescale 1ns / 1ps

package heq_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int LEVELS     = 256;
    localparam int PIX_W      = 8;
    localparam int OP_W       = 2;
    localparam int IDX_W      = $clog2(LEVELS);
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    // 510*cdf + N stays below 512*N
    localparam int DW         = CNT_W + 9;
    localparam int QBITS      = PIX_W;
    localparam int STEP_W     = $clog2(QBITS);

    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd2;

    localparam logic KIND_LEVEL = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic          sub;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DW-1:0] sum;
        logic          borrow;
    } alu_rsp_t;

endpackage

[sv/histogram_equalizer_top.sv]
// histogram equalizer top level: sequencer, histogram and level map memories
`timescale 1ns / 1ps

// Grey-level histogram equalizer for 8-bit pixels. An item is taken at a rising
// edge with start high and busy low; busy stays high while the item is worked.
// After reset the block runs a clearing pass over both 256-entry memories and is
// busy until it ends. A count item (operation 0) reads the bin as it is taken and
// writes it back incremented in S_CNT; counts beyond the pixel limit are dropped.
// A map item (operation 2) reads the level map as it is taken, and its result
// strobes in the cycle after S_MAP, with busy already low again. A build item
// (operation 1) walks all 256 bins through one shared adder / subtractor: per bin
// one read, one cdf add, two steps to form 510*cdf + N and eight restoring divide
// steps, then one level-map write; the done strobe follows the last bin. Results
// appear on result_kind and level for exactly one cycle with result_valid high;
// the receiver cannot stall them. Operation code 3 is taken and ignored.
module histogram_equalizer_top
    import heq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OP_W-1:0]  operation,
    input  logic [PIX_W-1:0] pixel,
    output logic             busy,
    output logic             result_valid,
    output logic             result_kind,
    output logic [PIX_W-1:0] level
);

    // one-hot sequencer states
    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,  // reset sweep over both memories
        S_IDLE  = 10'b00_0000_0010,  // waiting for an item
        S_CNT   = 10'b00_0000_0100,  // bin read back, write incremented count
        S_MAP   = 10'b00_0000_1000,  // level map read back, present result
        S_B_RD  = 10'b00_0001_0000,  // build: issue bin read
        S_B_ACC = 10'b00_0010_0000,  // build: cdf += bin, clear bin
        S_B_MUL = 10'b00_0100_0000,  // build: 512*cdf - 2*cdf
        S_B_ADN = 10'b00_1000_0000,  // build: + N, load divisor
        S_B_DIV = 10'b01_0000_0000,  // build: one restoring divide step
        S_B_WR  = 10'b10_0000_0000   // build: write mapped level
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;       // sweep / build bin index
    logic [PIX_W-1:0]  px_reg, px_next;         // pixel of a count item
    logic [CNT_W-1:0]  cdf_reg, cdf_next;       // running cumulative sum
    logic [CNT_W-1:0]  total_reg, total_next;   // pixels counted since last build
    logic [DW-1:0]     rem_reg, rem_next;       // partial remainder
    logic [DW-1:0]     dsh_reg, dsh_next;       // shifted divisor
    logic [QBITS-1:0]  quo_reg, quo_next;       // quotient bits
    logic [STEP_W-1:0] step_reg, step_next;     // divide step count

    logic             result_valid_reg, result_valid_next;
    logic             result_kind_reg, result_kind_next;
    logic [PIX_W-1:0] level_reg, level_next;

    // histogram memory ports
    logic             bin_we;
    logic [IDX_W-1:0] bin_waddr;
    logic [CNT_W-1:0] bin_wdata;
    logic [IDX_W-1:0] bin_raddr;
    logic [CNT_W-1:0] bin_rdata;

    // level map memory ports
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic [PIX_W-1:0] map_wdata;
    logic [PIX_W-1:0] map_rdata;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic accept;
    logic last_idx;
    logic room;

    assign accept   = start && (state_reg == S_IDLE);
    assign last_idx = (idx_reg == IDX_W'(LEVELS - 1));
    assign room     = (total_reg < CNT_W'(MAX_PIXELS));

    heq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (LEVELS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    heq_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LEVELS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (pixel),
        .rdata (map_rdata)
    );

    heq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // shared unit operand selection
    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_CNT:
            begin
                alu_req.a = DW'(bin_rdata);
                alu_req.b = DW'(1);
            end
            S_B_ACC:
            begin
                alu_req.a = DW'(cdf_reg);
                alu_req.b = DW'(bin_rdata);
            end
            S_B_MUL:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = DW'(cdf_reg) << 9;
                alu_req.b   = DW'(cdf_reg) << 1;
            end
            S_B_ADN:
            begin
                alu_req.a = rem_reg;
                alu_req.b = DW'(total_reg);
            end
            S_B_DIV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = rem_reg;
                alu_req.b   = dsh_reg;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // memory write and read addressing
    always_comb
    begin
        bin_we    = 1'b0;
        bin_waddr = idx_reg;
        bin_wdata = '0;
        map_we    = 1'b0;
        map_waddr = idx_reg;
        map_wdata = '0;
        // in idle the read follows the incoming pixel, else the build index
        bin_raddr = (state_reg == S_IDLE) ? pixel : idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                bin_we = 1'b1;
                map_we = 1'b1;
            end
            S_CNT:
            begin
                bin_we    = room;
                bin_waddr = px_reg;
                bin_wdata = alu_rsp.sum[CNT_W-1:0];
            end
            S_B_ACC:
            begin
                // bin read out, clear it for the next frame
                bin_we = 1'b1;
            end
            S_B_WR:
            begin
                map_we    = 1'b1;
                // empty histogram maps every level to zero
                map_wdata = (total_reg == '0) ? '0 : quo_reg;
            end
            default:
            begin
                bin_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        px_next           = px_reg;
        cdf_next          = cdf_reg;
        total_next        = total_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        result_valid_next = 1'b0;
        result_kind_next  = result_kind_reg;
        level_next        = level_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    px_next = pixel;
                    unique case (operation)
                        OP_COUNT:
                        begin
                            state_next = S_CNT;
                        end
                        OP_BUILD:
                        begin
                            idx_next   = '0;
                            cdf_next   = '0;
                            state_next = S_B_RD;
                        end
                        OP_MAP:
                        begin
                            state_next = S_MAP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                if (room)
                begin
                    total_next = total_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            S_MAP:
            begin
                result_valid_next = 1'b1;
                result_kind_next  = KIND_LEVEL;
                level_next        = map_rdata;
                state_next        = S_IDLE;
            end
            S_B_RD:
            begin
                state_next = S_B_ACC;
            end
            S_B_ACC:
            begin
                cdf_next   = alu_rsp.sum[CNT_W-1:0];
                state_next = S_B_MUL;
            end
            S_B_MUL:
            begin
                rem_next   = alu_rsp.sum;
                state_next = S_B_ADN;
            end
            S_B_ADN:
            begin
                // divisor 2N aligned to the top quotient bit
                rem_next   = alu_rsp.sum;
                dsh_next   = DW'(total_reg) << QBITS;
                quo_next   = '0;
                step_next  = '0;
                state_next = S_B_DIV;
            end
            S_B_DIV:
            begin
                if (!alu_rsp.borrow)
                begin
                    rem_next = alu_rsp.sum;
                end
                quo_next  = {quo_reg[QBITS-2:0], ~alu_rsp.borrow};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QBITS - 1))
                begin
                    state_next = S_B_WR;
                end
            end
            S_B_WR:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (last_idx)
                begin
                    total_next        = '0;
                    result_valid_next = 1'b1;
                    result_kind_next  = KIND_DONE;
                    level_next        = '0;
                    state_next        = S_IDLE;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            idx_reg          <= '0;
            total_reg        <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            total_reg        <= total_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        px_reg          <= px_next;
        cdf_reg         <= cdf_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quo_reg         <= quo_next;
        result_kind_reg <= result_kind_next;
        level_reg       <= level_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign level        = level_reg;

endmodule

[sv/heq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module heq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/heq_alu.sv]
// shared add / subtract-compare unit of the equalizer sequencer
`timescale 1ns / 1ps

module heq_alu
    import heq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [DW:0] wide;

    always_comb
    begin
        if (req.sub)
        begin
            wide = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            wide = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.sum    = wide[DW-1:0];
        // borrow out of a subtract means a < b
        rsp.borrow = req.sub & wide[DW];
    end

endmodule

[sv/heq_checker.sv]
// port-level checks of the histogram equalizer, bound to the top level
`timescale 1ns / 1ps
`include "histogram_equalizer_top_defines.svh"

module heq_checker
    import heq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic [OP_W-1:0]  operation,
    input logic             busy,
    input logic             result_valid,
    input logic             result_kind,
    input logic [PIX_W-1:0] level
);

    logic take;
    logic take_map;
    logic take_count;
    logic take_real;
    logic level_out;
    logic done_out;

    assign take       = start && !busy;
    assign take_map   = take && (operation == OP_MAP);
    assign take_count = take && (operation == OP_COUNT);
    assign take_real  = take && ((operation == OP_COUNT) || (operation == OP_BUILD)
                                 || (operation == OP_MAP));
    assign level_out  = result_valid && (result_kind == KIND_LEVEL);
    assign done_out   = result_valid && (result_kind == KIND_DONE);

    // a result strobe lasts one cycle
    `HEQ_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held")

    // a map item answers with a level from the result register after S_MAP
    `HEQ_ASSERT_NEXT(a_map_answer, take_map, ##1 level_out, "map item gave no level")

    // a count item gives no result
    `HEQ_ASSERT_NEXT(a_count_silent, take_count, !result_valid, "count item gave a result")

    // a build acknowledgement carries level zero
    `HEQ_ASSERT_NOW(a_done_level, done_out, level == '0, "build done with nonzero level")

    // a real item makes the block busy
    `HEQ_ASSERT_NEXT(a_busy_after_take, take_real, busy, "not busy after item")

endmodule

bind histogram_equalizer_top heq_checker u_heq_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for the histogram equalizer: directed and random frames
`timescale 1ns / 1ps

module tb_top;
    import heq_pkg::*;

    // operation code 3 has no name in the package; the block takes it and drops it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // random part stops once roughly this many meaningful items are queued
    localparam int RANDOM_ITEMS  = 1100;
    // a build walks all 256 bins, so allow well beyond that
    localparam int DRAIN_LIMIT   = 20000;
    // trailing cycles after the last result, enough to catch a stray strobe
    localparam int SETTLE_CYCLES = 50;

    // one item as the driver presents it, with its idle gap and hold-off flag
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] pix;
        int unsigned      gap;
        bit               drain;
    } pixel_item_t;

    // one result as the block should strobe it
    typedef struct {
        logic             kind;
        logic [PIX_W-1:0] level;
    } level_result_t;

    // clock, reset and block inputs, all known from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic [OP_W-1:0]  operation = OP_COUNT;
    logic [PIX_W-1:0] pixel     = '0;
    logic             busy;
    logic             result_valid;
    logic             result_kind;
    logic [PIX_W-1:0] level;

    // items waiting to be driven, and results still owed by the block
    pixel_item_t   pending_items[$];
    level_result_t expected_levels[$];

    // shadow copy of the block's histogram, pixel count and level map
    logic [CNT_W-1:0] bin_count [LEVELS];
    int unsigned      pixel_total;
    logic [PIX_W-1:0] level_map [LEVELS];

    // handshake bookkeeping shared between driver and monitor
    bit          took_item = 1'b0;   // written only by the monitor, at the rising edge
    bit          holding   = 1'b0;   // driver has an item on the ports with start high
    bit          loaded    = 1'b0;   // driver has popped an item and is sitting out its gap
    pixel_item_t cur_item;
    int unsigned gap_left  = 0;
    int          errors    = 0;

    histogram_equalizer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .pixel        (pixel),
        .busy         (busy),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .level        (level)
    );

    // 20 ns period, low half first
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // update the shadow state for one accepted item and queue any result it owes
    function automatic void predict_item(input logic [OP_W-1:0] op,
                                         input logic [PIX_W-1:0] pix);
        longint unsigned cdf;
        longint unsigned total;
        longint unsigned mapped;
        int              i;
        level_result_t   res;
        cdf   = 0;
        total = pixel_total;
        case (op)
            OP_COUNT:
            begin
                // counts past the pixel limit leave bin and total alone
                if (pixel_total < MAX_PIXELS)
                begin
                    bin_count[pix] = bin_count[pix] + 1'b1;
                    pixel_total    = pixel_total + 1;
                end
            end
            OP_BUILD:
            begin
                // running cdf, rounded to the nearest of 256 levels
                for (i = 0; i < LEVELS; i++)
                begin
                    cdf = cdf + bin_count[i];
                    if (total == 0)
                        level_map[i] = '0;
                    else
                    begin
                        mapped = (510 * cdf + total) / (2 * total);
                        if (mapped > 255)
                            mapped = 255;
                        level_map[i] = mapped[PIX_W-1:0];
                    end
                    bin_count[i] = '0;
                end
                pixel_total = 0;
                res.kind  = KIND_DONE;
                res.level = '0;
                expected_levels.insert(expected_levels.size(), res);
            end
            OP_MAP:
            begin
                res.kind  = KIND_LEVEL;
                res.level = level_map[pix];
                expected_levels.insert(expected_levels.size(), res);
            end
            default:
                ;
        endcase
    endfunction

    // idle gap before an item: mostly none or short, now and then a long one
    function automatic int unsigned idle_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                              input int unsigned gap, input bit drain);
        pixel_item_t item;
        item.op    = op;
        item.pix   = pix;
        item.gap   = gap;
        item.drain = drain;
        pending_items.insert(pending_items.size(), item);
    endtask

    // monitor: check the strobed result first, then predict the item taken at this edge
    always @(posedge clk)
    begin
        level_result_t want;
        took_item = rst_n && start && !busy;
        if (rst_n && result_valid)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("result with nothing expected: result_kind %0d level %0d",
                       result_kind, level);
                errors++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind mismatch: expected %0d, actual %0d",
                           want.kind, result_kind);
                    errors++;
                end
                if (level !== want.level)
                begin
                    $error("level mismatch: expected %0d, actual %0d", want.level, level);
                    errors++;
                end
            end
        end
        if (took_item)
            predict_item(operation, pixel);
    end

    // driver: works at the falling edge, one nonblocking write per port per step
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // the item on the ports went in at the last rising edge
            if (holding && took_item)
                holding = 1'b0;
            if (!holding && !loaded && pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                gap_left = cur_item.gap;
                loaded   = 1'b1;
            end
            if (loaded && !holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                // a hold-off item waits until every owed result has come back
                else if (!cur_item.drain || expected_levels.size() == 0)
                begin
                    holding = 1'b1;
                    loaded  = 1'b0;
                end
            end
        end
        start     <= holding;
        // junk on the data ports while start is low, the block must ignore it
        operation <= holding ? cur_item.op  : OP_W'($urandom_range(0, 3));
        pixel     <= holding ? cur_item.pix : PIX_W'($urandom_range(0, 255));
    end

    // run-time ceiling, far above the slowest legal run with every item a long build
    initial
    begin
        #(64'd500_000_000);
        $display("FAIL");
        $finish;
    end

    // stimulus, end of run and verdict
    initial
    begin
        int          random_items;
        int          waited;
        int          n_count;
        int          n_map;
        int          spread;
        bit          quiet;
        logic [7:0]  base;
        logic [1:0]  op;

        for (int i = 0; i < LEVELS; i++)
        begin
            bin_count[i] = '0;
            level_map[i] = '0;
        end
        pixel_total = 0;

        // map before any build reads the cleared table
        queue_item(OP_MAP, 8'd0, 0, 1'b0);
        queue_item(OP_MAP, 8'd255, 1, 1'b0);
        // unused code, either pixel pattern, no effect
        queue_item(OP_UNUSED, 8'hAA, 0, 1'b0);
        queue_item(OP_UNUSED, 8'h55, 0, 1'b0);
        // build on an empty histogram maps everything to zero
        queue_item(OP_BUILD, 8'd0, 0, 1'b0);
        queue_item(OP_MAP, 8'd128, 0, 1'b0);
        // small histogram over the pixel extremes
        queue_item(OP_COUNT, 8'd0, 0, 1'b0);
        queue_item(OP_COUNT, 8'd255, 0, 1'b0);
        queue_item(OP_COUNT, 8'd255, 2, 1'b0);
        queue_item(OP_COUNT, 8'd85, 0, 1'b0);
        queue_item(OP_COUNT, 8'd170, 0, 1'b0);
        queue_item(OP_UNUSED, 8'd255, 0, 1'b0);
        // sender holds off until the block has answered everything
        queue_item(OP_BUILD, 8'hFF, 0, 1'b1);
        queue_item(OP_MAP, 8'd0, 0, 1'b0);
        queue_item(OP_MAP, 8'd1, 0, 1'b0);
        queue_item(OP_MAP, 8'd85, 0, 1'b0);
        queue_item(OP_MAP, 8'd170, 3, 1'b0);
        queue_item(OP_MAP, 8'd254, 0, 1'b0);
        queue_item(OP_MAP, 8'd255, 0, 1'b0);
        // histogram was cleared by the last build
        queue_item(OP_BUILD, 8'd0, 0, 1'b0);
        queue_item(OP_MAP, 8'd255, 0, 1'b0);

        // random part: mostly whole frames (counts, build, maps), some noise bursts
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                base = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 7;
                    2:       spread = 63;
                    default: spread = 255;
                endcase
                n_count = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(0, 40);
                for (int i = 0; i < n_count; i++)
                begin
                    queue_item(OP_COUNT, base + 8'($urandom_range(0, spread)),
                               idle_gap(quiet), 1'b0);
                    if ($urandom_range(0, 19) == 0)
                        queue_item(OP_UNUSED, 8'($urandom_range(0, 255)), idle_gap(quiet), 1'b0);
                end
                queue_item(OP_BUILD, 8'($urandom_range(0, 255)), idle_gap(quiet),
                           ($urandom_range(0, 5) == 0));
                n_map = $urandom_range(1, 24);
                for (int i = 0; i < n_map; i++)
                    queue_item(OP_MAP, ($urandom_range(0, 1) == 0)
                                       ? base + 8'($urandom_range(0, spread))
                                       : 8'($urandom_range(0, 255)),
                               idle_gap(quiet), (i == 0) && ($urandom_range(0, 7) == 0));
                random_items += n_count + 1 + n_map;
            end
            else
            begin
                // noise: any code in any order, including broken frames
                repeat ($urandom_range(1, 10))
                begin
                    op = OP_W'($urandom_range(0, 3));
                    queue_item(op, 8'($urandom_range(0, 255)), idle_gap(quiet), 1'b0);
                    if (op != OP_UNUSED)
                        random_items++;
                end
            end
        end

        // reset held low, then released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for the driver to run dry
        do
            @(posedge clk);
        while (pending_items.size() > 0 || loaded || holding);

        // then for the last owed result, with a bound
        waited = 0;
        while (expected_levels.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end

        if (expected_levels.size() > 0)
            $display("FAIL");
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (errors == 0 && expected_levels.size() == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/heq_pkg.sv
sv/heq_ram.sv
sv/heq_alu.sv
sv/histogram_equalizer_top.sv
sv/heq_checker.sv
tb/tb_top.sv
